FILE: hdl/iiee_pkg.sv
// Shared constants for the infix integer expression evaluator.
`default_nettype none
package iiee_pkg;

  localparam int VALUE_BITS = 32;
  localparam int CNT_BITS   = $clog2(VALUE_BITS);
  localparam int IN_BITS    = 8;
  localparam int OUT_BITS   = ((VALUE_BITS + 2 + 7) / 8) * 8;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [1:0] PH_OPERAND  = 2'd0;
  localparam logic [1:0] PH_NUMBER   = 2'd1;
  localparam logic [1:0] PH_OPERATOR = 2'd2;
  localparam logic [1:0] PH_DONE     = 2'd3;

  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_FIRST = 2'd1;  // add or multiply
  localparam logic [1:0] PEND_SECOND = 2'd2; // subtract or divide

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_BAD_IN   = 2'd1;
  localparam logic [1:0] STAT_DIV_ZERO = 2'd2;

endpackage
`default_nettype wire

FILE: hdl/iiee_div.sv
// Iterative signed divider, truncating toward zero, one quotient bit per cycle.
`default_nettype none
module iiee_div (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic [iiee_pkg::VALUE_BITS-1:0]  dividend_i,
  input  wire logic [iiee_pkg::VALUE_BITS-1:0]  divisor_i,
  output logic                                  done_o,
  output logic [iiee_pkg::VALUE_BITS-1:0]       quotient_o
);

  localparam int W = iiee_pkg::VALUE_BITS;

  logic                             busy_q, busy_d;
  logic                             fin_q, fin_d;
  logic [iiee_pkg::CNT_BITS-1:0]    cnt_q;
  logic [W-1:0]                     rem_q, quo_q, dvs_q;
  logic                             neg_q;
  logic [W:0]                       shifted, trial;

  assign shifted = {rem_q, quo_q[W-1]};
  assign trial   = shifted - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    fin_d  = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
    end else if (busy_q && cnt_q == '0) begin
      busy_d = 1'b0;
      fin_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      fin_q  <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i[W-1] ? (W'(0) - dividend_i) : dividend_i;
      dvs_q <= divisor_i[W-1] ? (W'(0) - divisor_i) : divisor_i;
      rem_q <= '0;
      neg_q <= dividend_i[W-1] ^ divisor_i[W-1];
      cnt_q <= iiee_pkg::CNT_BITS'(W - 1);
    end else if (busy_q) begin
      // restoring step: keep the trial remainder when it did not go negative
      if (!trial[W]) begin
        rem_q <= trial[W-1:0];
        quo_q <= {quo_q[W-2:0], 1'b1};
      end else begin
        rem_q <= shifted[W-1:0];
        quo_q <= {quo_q[W-2:0], 1'b0};
      end
      cnt_q <= cnt_q - 1'b1;
    end
  end

  assign done_o     = fin_q;
  assign quotient_o = neg_q ? (W'(0) - quo_q) : quo_q;

endmodule
`default_nettype wire

FILE: hdl/infix_integer_expression_evaluator.sv
// Byte-serial evaluator of one integer expression with + - * / and two precedence levels.
//
// Input stream: one ASCII byte per request on s_axis, tlast marks the final byte of an
// expression. Whitespace is skipped; numbers take any number of prefix minus signs.
// Output stream: one request per expression on m_axis, issued after the final byte:
// value in tdata[31:0], status in tdata[33:32] (0 ok, 1 wrong input, 2 divide by zero).
// Value is zero whenever status is nonzero.
// A digit, sign, whitespace or ignored byte is handled in the idle step. A byte that
// completes an operand passes through the close and apply steps, with a multiply step
// between them for a multiply; a divide checks the divisor for zero, else waits on the
// shared divider, which loads, resolves one quotient bit per cycle and fixes the sign.
// The final byte ends in the emit step. s_axis_tready is low while a byte is in work.
// The result sits in an output register; a new expression may start while it waits.
// If the receiver stalls, the next final byte holds in the emit step until the
// register frees, and input stays blocked meanwhile.
// Reset returns the parser's control and accumulator state to "expect operand" and drops any pending result.
`default_nettype none
module infix_integer_expression_evaluator (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  wire logic [iiee_pkg::IN_BITS-1:0]   s_axis_tdata_i,  // [7:0] char_byte
  input  wire logic                           s_axis_tlast_i,  // end_of_text
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  output logic [iiee_pkg::OUT_BITS-1:0]       m_axis_tdata_o   // [31:0] value, [33:32] status
);

  localparam int W = iiee_pkg::VALUE_BITS;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CLOSE  = 3'd1;
  localparam logic [2:0] ST_MUL    = 3'd2;
  localparam logic [2:0] ST_DIVCHK = 3'd3;
  localparam logic [2:0] ST_DIV    = 3'd4;
  localparam logic [2:0] ST_APPLY  = 3'd5;
  localparam logic [2:0] ST_EMIT   = 3'd6;

  logic [2:0]   state_q, state_d;
  logic [W-1:0] sum_q, sum_d, term_q, term_d, lit_q, lit_d, op_q, op_d;
  logic [1:0]   add_pend_q, add_pend_d, mul_pend_q, mul_pend_d;
  logic         parity_q, parity_d;
  logic [1:0]   phase_q, phase_d;
  logic [1:0]   err_q, err_d;
  logic [7:0]   char_q, char_d;
  logic         last_q, last_d, final_q, final_d;
  logic         out_valid_q, out_valid_d;
  logic [W-1:0] out_value_q, out_value_d;
  logic [1:0]   out_status_q, out_status_d;

  logic         accept, is_space, is_digit, need_take, div_start, div_done;
  logic [W-1:0] digit_val, lit_x10, operand, fold_val, quotient, product;
  logic [7:0]   in_char;

  assign in_char   = s_axis_tdata_i[7:0];
  assign accept    = s_axis_tvalid_i && s_axis_tready_o;
  assign is_space  = (in_char == iiee_pkg::CH_SPACE) ||
                     (in_char >= iiee_pkg::CH_TAB && in_char <= iiee_pkg::CH_CR);
  assign is_digit  = (in_char >= iiee_pkg::CH_ZERO) && (in_char <= iiee_pkg::CH_NINE);
  assign digit_val = W'(in_char[3:0]);
  assign lit_x10   = (lit_q << 3) + (lit_q << 1);
  assign operand   = parity_q ? (W'(0) - lit_q) : lit_q;
  assign product   = term_q * op_q;

  always_comb begin
    case (add_pend_q)
      iiee_pkg::PEND_FIRST:  fold_val = sum_q + term_q;
      iiee_pkg::PEND_SECOND: fold_val = sum_q - term_q;
      default:               fold_val = term_q;
    endcase
  end

  iiee_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (term_q),
    .divisor_i  (op_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    state_d      = state_q;
    sum_d        = sum_q;
    term_d       = term_q;
    lit_d        = lit_q;
    op_d         = op_q;
    add_pend_d   = add_pend_q;
    mul_pend_d   = mul_pend_q;
    parity_d     = parity_q;
    phase_d      = phase_q;
    err_d        = err_q;
    char_d       = char_q;
    last_d       = last_q;
    final_d      = final_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    need_take    = 1'b0;
    div_start    = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          char_d = in_char;
          last_d = s_axis_tlast_i;
          case (phase_q)
            iiee_pkg::PH_OPERAND: begin
              if (is_space) begin
                phase_d = phase_q;
              end else if (in_char == iiee_pkg::CH_MINUS) begin
                parity_d = !parity_q;
              end else if (is_digit) begin
                lit_d   = digit_val;
                phase_d = iiee_pkg::PH_NUMBER;
              end else begin
                err_d   = iiee_pkg::STAT_BAD_IN;
                phase_d = iiee_pkg::PH_DONE;
              end
            end
            iiee_pkg::PH_NUMBER: begin
              if (is_digit) begin
                lit_d = lit_x10 + digit_val;
              end else if (is_space) begin
                phase_d = iiee_pkg::PH_OPERATOR;
              end else begin
                need_take = 1'b1;
              end
            end
            iiee_pkg::PH_OPERATOR: begin
              need_take = !is_space;
            end
            default: begin
              phase_d = phase_q;
            end
          endcase
          if (need_take) begin
            final_d = 1'b0;
            state_d = ST_CLOSE;
          end else if (s_axis_tlast_i) begin
            if (phase_d == iiee_pkg::PH_NUMBER || phase_d == iiee_pkg::PH_OPERATOR) begin
              final_d = 1'b1;
              state_d = ST_CLOSE;
            end else begin
              if (phase_d == iiee_pkg::PH_OPERAND) begin
                err_d = iiee_pkg::STAT_BAD_IN;
              end
              state_d = ST_EMIT;
            end
          end
        end
      end
      ST_CLOSE: begin
        op_d     = operand;
        lit_d    = '0;
        parity_d = 1'b0;
        case (mul_pend_q)
          iiee_pkg::PEND_FIRST:  state_d = ST_MUL;
          iiee_pkg::PEND_SECOND: state_d = ST_DIVCHK;
          default: begin
            term_d  = operand;
            state_d = ST_APPLY;
          end
        endcase
      end
      ST_MUL: begin
        term_d     = product;
        mul_pend_d = iiee_pkg::PEND_NONE;
        state_d    = ST_APPLY;
      end
      ST_DIVCHK: begin
        if (op_q == '0) begin
          err_d   = iiee_pkg::STAT_DIV_ZERO;
          phase_d = iiee_pkg::PH_DONE;
          state_d = last_q ? ST_EMIT : ST_IDLE;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          term_d     = quotient;
          mul_pend_d = iiee_pkg::PEND_NONE;
          state_d    = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (final_q) begin
          sum_d      = fold_val;
          add_pend_d = iiee_pkg::PEND_NONE;
          phase_d    = iiee_pkg::PH_DONE;
          state_d    = ST_EMIT;
        end else begin
          case (char_q)
            iiee_pkg::CH_STAR: begin
              mul_pend_d = iiee_pkg::PEND_FIRST;
              phase_d    = iiee_pkg::PH_OPERAND;
            end
            iiee_pkg::CH_SLASH: begin
              mul_pend_d = iiee_pkg::PEND_SECOND;
              phase_d    = iiee_pkg::PH_OPERAND;
            end
            iiee_pkg::CH_PLUS: begin
              sum_d      = fold_val;
              add_pend_d = iiee_pkg::PEND_FIRST;
              phase_d    = iiee_pkg::PH_OPERAND;
            end
            iiee_pkg::CH_MINUS: begin
              sum_d      = fold_val;
              add_pend_d = iiee_pkg::PEND_SECOND;
              phase_d    = iiee_pkg::PH_OPERAND;
            end
            default: begin
              // any other character ends the expression
              sum_d      = fold_val;
              add_pend_d = iiee_pkg::PEND_NONE;
              phase_d    = iiee_pkg::PH_DONE;
            end
          endcase
          if (last_q) begin
            if (phase_d == iiee_pkg::PH_OPERAND) begin
              err_d = iiee_pkg::STAT_BAD_IN;
            end
            state_d = ST_EMIT;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d  = 1'b1;
          out_value_d  = (err_q == iiee_pkg::STAT_OK) ? sum_q : '0;
          out_status_d = err_q;
          sum_d        = '0;
          term_d       = '0;
          lit_d        = '0;
          add_pend_d   = iiee_pkg::PEND_NONE;
          mul_pend_d   = iiee_pkg::PEND_NONE;
          parity_d     = 1'b0;
          phase_d      = iiee_pkg::PH_OPERAND;
          err_d        = iiee_pkg::STAT_OK;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      term_q      <= '0;
      lit_q       <= '0;
      add_pend_q  <= iiee_pkg::PEND_NONE;
      mul_pend_q  <= iiee_pkg::PEND_NONE;
      parity_q    <= 1'b0;
      phase_q     <= iiee_pkg::PH_OPERAND;
      err_q       <= iiee_pkg::STAT_OK;
      last_q      <= 1'b0;
      final_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      term_q      <= term_d;
      lit_q       <= lit_d;
      add_pend_q  <= add_pend_d;
      mul_pend_q  <= mul_pend_d;
      parity_q    <= parity_d;
      phase_q     <= phase_d;
      err_q       <= err_d;
      last_q      <= last_d;
      final_q     <= final_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    char_q       <= char_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = iiee_pkg::OUT_BITS'({out_status_q, out_value_q});

endmodule
`default_nettype wire
